### rtl/polled_change_event_monitor_defines.svh
// assertion macros for the polled change event monitor
// no dependencies; included by the files that carry assertions
`ifndef POLLED_CHANGE_EVENT_MONITOR_DEFINES_SVH
`define POLLED_CHANGE_EVENT_MONITOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PCEM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcem implication check failed");

// next-cycle implication, disabled during reset
`define PCEM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcem next-cycle check failed");

`endif

### rtl/pcem_pkg.sv
// package for the polled change event monitor: beat types, codes and constants
// no dependencies; imported by polled_change_event_monitor and the testbench
package pcem_pkg;

    localparam int CHANNELS_DEFAULT = 4;
    localparam int NREGS_PER        = 4;
    localparam int REG_SEL_W        = 2;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 16;
    localparam int REG_POLL_BASE    = 4;

    localparam logic [15:0] ON_TIME_MAX = 16'hFFFE;
    localparam logic [15:0] ON_TIME_OFF = 16'hFFFF;
    localparam logic [15:0] SCHED_RESET = 16'hFFFF;

    localparam logic [1:0] FLAG_NONE = 2'b00;
    localparam logic [1:0] FLAG_PREV = 2'b01;
    localparam logic [1:0] FLAG_REQ  = 2'b10;
    localparam int FLAG_PREV_BIT = 0;
    localparam int FLAG_REQ_BIT  = 1;

    localparam logic CMD_TICK     = 1'b0;
    localparam logic CMD_RESPONSE = 1'b1;

    localparam logic [1:0] KIND_READ_REQ  = 2'd0;
    localparam logic [1:0] KIND_TRIGGER   = 2'd1;
    localparam logic [1:0] KIND_TICK_DONE = 2'd2;
    localparam logic [1:0] KIND_RSP_ACK   = 2'd3;

    typedef struct packed {
        logic        cmd;
        logic        ignition_on;
        logic [1:0]  channel;
        logic        read_done;
        logic [31:0] read_value;
        logic        event_started;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  out_channel;
        logic [15:0] elapsed_ticks;
        logic        last;
    } out_item_t;

    // one channel's stored state
    typedef struct packed {
        logic [15:0] sched;
        logic [1:0]  flags;
        logic [31:0] last_value;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{sched: SCHED_RESET, flags: FLAG_NONE, last_value: 32'd0};

endpackage

### rtl/polled_change_event_monitor.sv
// polled change event monitor top level: sequencer, channel memory, config registers
// depends on pcem_pkg and polled_change_event_monitor_defines.svh
`include "polled_change_event_monitor_defines.svh"

// Polled change-of-value monitor. Tick beats (cmd 0) advance a wrapping tick count and,
// with the ignition on, a saturating on-time count; every channel whose start offset has
// passed is then scheduled by its poll interval and, while its read is pending, yields a
// read request carrying the ticks elapsed since it was scheduled, followed by one tick-done
// beat. Response beats (cmd 1) hand back a channel's 32-bit value; a changed value of a
// started event yields a trigger, followed by one acknowledge. An ignition-off tick clears
// every channel at once. Per-channel state (schedule time, flags, last value) lives in one
// synchronous memory with a registered read port; a valid bit per entry stands in for the
// reset value, so no clearing pass is needed. One beat is worked on at a time: an
// ignition-on tick has an accept state that issues the first read, a read-modify-write of
// each channel in turn and a tick-done beat; an ignition-off tick an accept state and the
// tick-done beat; a response an accept state, a check that writes back and, with a trigger,
// an acknowledge. Every result beat, read requests included, waits while the single result
// register is full and not taken. Config writes are taken in any cycle, ready is always high.
module polled_change_event_monitor
#(
    parameter int CHANNELS = pcem_pkg::CHANNELS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  pcem_pkg::in_item_t                 item,
    output logic                               result_valid,
    input  logic                               result_ready,
    output pcem_pkg::out_item_t                result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pcem_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pcem_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import pcem_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_TICK_EX = 5'b00010,
        ST_DONE    = 5'b00100,
        ST_RSP_EX  = 5'b01000,
        ST_ACK     = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [15:0] tick_reg;
    logic [15:0] on_time_reg;
    logic [CHANNELS-1:0] valid_reg;
    logic [15:0] start_offset_reg [NREGS_PER];
    logic [15:0] poll_interval_reg [NREGS_PER];
    in_item_t rsp_reg;
    out_item_t result_reg, result_next;
    logic result_valid_reg;

    // channel memory
    entry_t mem_array [CHANNELS];
    entry_t rd_data_reg;
    logic rd_valid_reg;
    logic rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t wr_data;

    // control strobes
    logic item_fire, out_free, out_load, tick_inc, clear_all;
    logic on_time_load;
    logic [15:0] on_time_new;

    // per-channel datapath
    entry_t ent, ent_new;
    logic [REG_SEL_W-1:0] reg_sel;
    logic in_table, active, emit, walk_last;
    logic [15:0] offs, ival, el_old, el_new;
    logic rsp_in_range, hit, trig;

    assign item_ready   = (state_reg == ST_IDLE);
    assign item_fire    = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;
    assign out_free     = !result_valid_reg || result_ready;

    // stored entry, or its reset value when never written since the last clear
    assign ent = rd_valid_reg ? rd_data_reg : ENTRY_RESET;

    // register lookup; channels past the register table use offset and interval 0
    assign reg_sel   = REG_SEL_W'(idx_reg);
    assign in_table  = (int'(idx_reg) < NREGS_PER);
    assign offs      = in_table ? start_offset_reg[reg_sel] : 16'd0;
    assign ival      = in_table ? poll_interval_reg[reg_sel] : 16'd0;
    assign walk_last = (int'(idx_reg) == CHANNELS - 1);

    // schedule step of the tick walk
    always_comb
    begin
        active = (on_time_reg >= offs);
        el_old = tick_reg - ent.sched;
        ent_new = ent;
        if (active)
        begin
            if (ent.flags == FLAG_NONE)
            begin
                ent_new.flags = FLAG_REQ;
                ent_new.sched = tick_reg;
            end
            else if (!ent.flags[FLAG_REQ_BIT] && (el_old >= ival))
            begin
                ent_new.flags = ent.flags | FLAG_REQ;
                ent_new.sched = tick_reg;
            end
        end
        emit   = active && ent_new.flags[FLAG_REQ_BIT];
        el_new = tick_reg - ent_new.sched;
    end

    // response check
    assign rsp_in_range = (int'(rsp_reg.channel) < CHANNELS);
    assign hit  = rsp_in_range && rsp_reg.read_done && ent.flags[FLAG_REQ_BIT];
    assign trig = hit && ent.flags[FLAG_PREV_BIT] && (ent.last_value != rsp_reg.read_value)
                  && rsp_reg.event_started;

    // on-time count for an ignition-on tick
    always_comb
    begin
        if (on_time_reg < ON_TIME_MAX)
        begin
            on_time_new = on_time_reg + 16'd1;
        end
        else if (on_time_reg == ON_TIME_OFF)
        begin
            on_time_new = 16'd0;
        end
        else
        begin
            on_time_new = on_time_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;
        wr_en        = 1'b0;
        wr_data      = ent_new;
        out_load     = 1'b0;
        result_next  = result_reg;
        tick_inc     = 1'b0;
        clear_all    = 1'b0;
        on_time_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    if (item.cmd == CMD_TICK)
                    begin
                        if (item.ignition_on)
                        begin
                            // start the walk at channel 0
                            on_time_load = 1'b1;
                            idx_next     = '0;
                            rd_en        = 1'b1;
                            rd_addr      = '0;
                            state_next   = ST_TICK_EX;
                        end
                        else
                        begin
                            clear_all  = (on_time_reg != ON_TIME_OFF);
                            state_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        idx_next   = IDX_W'(item.channel);
                        rd_en      = (int'(item.channel) < CHANNELS);
                        rd_addr    = IDX_W'(item.channel);
                        state_next = ST_RSP_EX;
                    end
                end
            end
            ST_TICK_EX:
            begin
                // hold while a request waits for the result register
                if (!emit || out_free)
                begin
                    wr_en = active;
                    if (emit)
                    begin
                        out_load    = 1'b1;
                        result_next = '{kind: KIND_READ_REQ, out_channel: 2'(idx_reg),
                                        elapsed_ticks: el_new, last: 1'b0};
                    end
                    if (walk_last)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    tick_inc    = 1'b1;
                    result_next = '{kind: KIND_TICK_DONE, out_channel: 2'd0,
                                    elapsed_ticks: 16'd0, last: 1'b1};
                    state_next  = ST_IDLE;
                end
            end
            ST_RSP_EX:
            begin
                if (out_free)
                begin
                    wr_en   = hit;
                    wr_data = '{sched: ent.sched, flags: FLAG_PREV,
                                last_value: rsp_reg.read_value};
                    out_load = 1'b1;
                    if (trig)
                    begin
                        result_next = '{kind: KIND_TRIGGER, out_channel: rsp_reg.channel,
                                        elapsed_ticks: 16'd0, last: 1'b0};
                        state_next  = ST_ACK;
                    end
                    else
                    begin
                        result_next = '{kind: KIND_RSP_ACK, out_channel: 2'd0,
                                        elapsed_ticks: 16'd0, last: 1'b1};
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    result_next = '{kind: KIND_RSP_ACK, out_channel: 2'd0,
                                    elapsed_ticks: 16'd0, last: 1'b1};
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            tick_reg         <= 16'd0;
            on_time_reg      <= ON_TIME_OFF;
            valid_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (tick_inc)
            begin
                tick_reg <= tick_reg + 16'd1;
            end
            if (on_time_load)
            begin
                on_time_reg <= on_time_new;
            end
            else if (clear_all)
            begin
                on_time_reg <= ON_TIME_OFF;
            end
            // ignition off: every channel back to its reset value
            if (clear_all)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREGS_PER; i++)
            begin
                start_offset_reg[i]  <= 16'd0;
                poll_interval_reg[i] <= 16'd0;
            end
        end
        else if (cfg_valid && cfg_ready && (int'(cfg_index[REG_SEL_W-1:0]) < CHANNELS))
        begin
            if (cfg_index >= CFG_INDEX_W'(REG_POLL_BASE))
            begin
                poll_interval_reg[cfg_index[REG_SEL_W-1:0]] <= cfg_data;
            end
            else
            begin
                start_offset_reg[cfg_index[REG_SEL_W-1:0]] <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            rsp_reg <= item;
        end
        if (out_load)
        begin
            result_reg <= result_next;
        end
    end

    // channel memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg  <= mem_array[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
        if (wr_en)
        begin
            mem_array[idx_reg] <= wr_data;
        end
    end

    `PCEM_ASSERT_IMP(a_no_rw_same_entry, clk, rst_n, rd_en && wr_en, rd_addr != idx_reg)
    `PCEM_ASSERT_NXT(a_off_tick_clears, clk, rst_n,
                     item_fire && (item.cmd == CMD_TICK) && !item.ignition_on, valid_reg == '0)
    `PCEM_ASSERT_IMP(a_walk_ignition_on, clk, rst_n,
                     state_reg == ST_TICK_EX, on_time_reg != ON_TIME_OFF)
    `PCEM_ASSERT_IMP(a_final_beat_last, clk, rst_n,
                     result_valid && ((result.kind == KIND_TICK_DONE)
                                      || (result.kind == KIND_RSP_ACK)),
                     result.last)

endmodule

### verif/testbench.sv
// self-checking testbench for the polled change event monitor
// depends on pcem_pkg and the polled_change_event_monitor rtl; reads no files
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pcem_pkg::*;

    localparam int          N_CHAN      = CHANNELS_DEFAULT;
    localparam int          HOLD_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT = 200_000;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_data;
    } reg_write_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    in_item_t    item = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    out_item_t   result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // stimulus queues filled by the sequence below, drained by the drivers
    in_item_t    pending_items [$];
    reg_write_t  pending_writes [$];
    out_item_t   expected_beats [$];

    // idling knobs, percent of cycles
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // long receiver hold-off, requested by bumping hold_req
    int unsigned hold_req = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    int unsigned error_count = 0;
    int unsigned result_count = 0;

    // predicted state of the block
    logic [15:0] on_ticks;
    logic [15:0] tick_no;
    logic [15:0] sched_at [N_CHAN];
    logic [1:0]  chan_flags [N_CHAN];
    logic [31:0] prev_value [N_CHAN];
    logic [15:0] start_after [N_CHAN];
    logic [15:0] poll_every [N_CHAN];

    // value the traffic generator last returned per channel
    logic [31:0] value_hint [N_CHAN];

    polled_change_event_monitor u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void flag_error(string msg);
        error_count++;
        if (error_count <= 10)
        begin
            $display("%s", msg);
        end
    endfunction

    function automatic out_item_t make_beat(logic [1:0] kind, logic [1:0] ch,
                                            logic [15:0] el, logic last_beat);
        out_item_t b;
        b.kind          = kind;
        b.out_channel   = ch;
        b.elapsed_ticks = el;
        b.last          = last_beat;
        return b;
    endfunction

    // ignition off drops every channel back to its unscheduled state
    function automatic void clear_channels();
        for (int c = 0; c < N_CHAN; c++)
        begin
            sched_at[c]   = SCHED_RESET;
            chan_flags[c] = FLAG_NONE;
            prev_value[c] = '0;
        end
    endfunction

    function automatic void apply_reg_write(reg_write_t w);
        if (w.reg_index < NREGS_PER)
        begin
            start_after[w.reg_index[REG_SEL_W-1:0]] = w.reg_data;
        end
        else if (w.reg_index < 2 * NREGS_PER)
        begin
            poll_every[w.reg_index[REG_SEL_W-1:0]] = w.reg_data;
        end
    endfunction

    // works out the result beats of one accepted input beat
    function automatic void predict_item(in_item_t it);
        logic [15:0] since;
        int unsigned ch;
        if (it.cmd == CMD_TICK)
        begin
            if (it.ignition_on)
            begin
                // saturating on-time count, all ones means off
                if (on_ticks < ON_TIME_MAX)
                begin
                    on_ticks = on_ticks + 16'd1;
                end
                else if (on_ticks == ON_TIME_OFF)
                begin
                    on_ticks = '0;
                end
                for (int c = 0; c < N_CHAN; c++)
                begin
                    if (on_ticks >= start_after[c])
                    begin
                        since = tick_no - sched_at[c];
                        // never polled, or idle with its interval used up
                        if (chan_flags[c] == FLAG_NONE
                            || (!chan_flags[c][FLAG_REQ_BIT] && since >= poll_every[c]))
                        begin
                            chan_flags[c] = chan_flags[c] | FLAG_REQ;
                            sched_at[c]   = tick_no;
                        end
                        if (chan_flags[c][FLAG_REQ_BIT])
                        begin
                            since = tick_no - sched_at[c];
                            expected_beats.push_back(make_beat(KIND_READ_REQ, 2'(c), since, 1'b0));
                        end
                    end
                end
            end
            else if (on_ticks != ON_TIME_OFF)
            begin
                on_ticks = ON_TIME_OFF;
                clear_channels();
            end
            // tick count runs whether the ignition is on or not
            tick_no = tick_no + 16'd1;
            expected_beats.push_back(make_beat(KIND_TICK_DONE, 2'd0, 16'd0, 1'b1));
        end
        else
        begin
            ch = it.channel;
            // only a finished read of a pending request changes anything
            if (it.read_done && chan_flags[ch][FLAG_REQ_BIT])
            begin
                if (chan_flags[ch][FLAG_PREV_BIT] && prev_value[ch] != it.read_value
                    && it.event_started)
                begin
                    expected_beats.push_back(make_beat(KIND_TRIGGER, 2'(ch), 16'd0, 1'b0));
                end
                chan_flags[ch] = FLAG_PREV;
                prev_value[ch] = it.read_value;
            end
            expected_beats.push_back(make_beat(KIND_RSP_ACK, 2'd0, 16'd0, 1'b1));
        end
    endfunction

    // input beat driver: offers the next queued beat unless idling this cycle
    always @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            predict_item(item);
        end
        if (!item_valid || item_ready)
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item       <= pending_items.pop_front();
                item_valid <= 1'b1;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // register write driver, fed only while the block is idle
    always @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
        begin
            apply_reg_write('{reg_index: cfg_index, reg_data: cfg_data});
        end
        if (!cfg_valid || cfg_ready)
        begin
            if (pending_writes.size() != 0)
            begin
                {cfg_index, cfg_data} <= pending_writes.pop_front();
                cfg_valid <= 1'b1;
            end
            else
            begin
                cfg_valid <= 1'b0;
            end
        end
    end

    // long hold-off counter, runs on its own so the sender keeps offering beats
    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        result_ready <= (hold_left == 0) && (hold_seen == hold_req)
                        && ($urandom_range(99) >= recv_stall_pct);
    end

    // result monitor: every accepted beat against the oldest expectation
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            result_count++;
            if (expected_beats.size() == 0)
            begin
                flag_error($sformatf("beat %0d unexpected: kind %0d ch %0d elapsed %0d last %0d",
                                     result_count, result.kind, result.out_channel,
                                     result.elapsed_ticks, result.last));
            end
            else
            begin
                want = expected_beats.pop_front();
                if (result.kind !== want.kind || result.out_channel !== want.out_channel
                    || result.elapsed_ticks !== want.elapsed_ticks || result.last !== want.last)
                begin
                    flag_error($sformatf({"beat %0d mismatch: expected kind %0d ch %0d ",
                                          "elapsed %0d last %0d, got kind %0d ch %0d ",
                                          "elapsed %0d last %0d"},
                                         result_count, want.kind, want.out_channel,
                                         want.elapsed_ticks, want.last, result.kind,
                                         result.out_channel, result.elapsed_ticks,
                                         result.last));
                end
            end
        end
    end

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_items.size() != 0 || item_valid || expected_beats.size() != 0
               || pending_writes.size() != 0 || cfg_valid);
    endtask

    // unused fields of a beat carry random bits
    task automatic queue_tick(logic ign);
        in_item_t t;
        t             = in_item_t'({$urandom, 6'($urandom)});
        t.cmd         = CMD_TICK;
        t.ignition_on = ign;
        pending_items.push_back(t);
    endtask

    task automatic queue_response(logic [1:0] ch, logic done, logic [31:0] val,
                                  logic started);
        in_item_t t;
        t               = in_item_t'({$urandom, 6'($urandom)});
        t.cmd           = CMD_RESPONSE;
        t.channel       = ch;
        t.read_done     = done;
        t.read_value    = val;
        t.event_started = started;
        pending_items.push_back(t);
    endtask

    task automatic load_settings(logic [15:0] offs [N_CHAN], logic [15:0] ivals [N_CHAN]);
        wait_drained();
        for (int c = 0; c < N_CHAN; c++)
        begin
            pending_writes.push_back('{reg_index: CFG_INDEX_W'(c), reg_data: offs[c]});
            pending_writes.push_back('{reg_index: CFG_INDEX_W'(REG_POLL_BASE + c),
                                       reg_data: ivals[c]});
        end
        wait_drained();
    endtask

    // mostly short offsets and intervals so channels poll often, now and then an extreme
    task automatic load_random_settings();
        logic [15:0] offs [N_CHAN];
        logic [15:0] ivals [N_CHAN];
        for (int c = 0; c < N_CHAN; c++)
        begin
            case ($urandom_range(9))
                0: offs[c] = ON_TIME_MAX;
                1: offs[c] = 16'($urandom_range(5, 40));
                default: offs[c] = 16'($urandom_range(0, 3));
            endcase
            case ($urandom_range(9))
                0: ivals[c] = 16'hFFFF;
                1: ivals[c] = 16'($urandom);
                default: ivals[c] = 16'($urandom_range(0, 3));
            endcase
        end
        load_settings(offs, ivals);
    endtask

    // a tick followed by a few responses, with some stray beats mixed in
    task automatic queue_traffic(int unsigned n_items);
        int unsigned n;
        int unsigned ch;
        logic [31:0] val;
        n = 0;
        while (n < n_items)
        begin
            if ($urandom_range(99) < 6)
            begin
                pending_items.push_back(in_item_t'({$urandom, 6'($urandom)}));
                n++;
            end
            else
            begin
                queue_tick($urandom_range(99) < 93);
                n++;
                repeat ($urandom_range(0, 4))
                begin
                    ch = $urandom_range(N_CHAN - 1);
                    case ($urandom_range(9))
                        0, 1, 2, 3: val = value_hint[ch];
                        4, 5: val = $urandom;
                        6, 7: val = value_hint[ch] ^ (32'd1 << $urandom_range(31));
                        8: val = '0;
                        default: val = '1;
                    endcase
                    value_hint[ch] = val;
                    queue_response(2'(ch), $urandom_range(99) < 85, val,
                                   $urandom_range(99) < 85);
                    n++;
                end
            end
        end
    endtask

    initial
    begin
        logic [15:0] offs [N_CHAN];
        logic [15:0] ivals [N_CHAN];
        int unsigned send_tab [4];
        int unsigned stall_tab [4];

        send_tab  = '{0, 47, 0, 27};
        stall_tab = '{0, 0, 47, 27};
        on_ticks  = ON_TIME_OFF;
        tick_no   = '0;
        clear_channels();
        for (int c = 0; c < N_CHAN; c++)
        begin
            start_after[c] = '0;
            poll_every[c]  = '0;
            value_hint[c]  = '0;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: staggered starts, one channel that never starts, both interval extremes
        offs  = '{16'd0, 16'd1, 16'd3, ON_TIME_MAX};
        ivals = '{16'd0, 16'd2, 16'd5, 16'hFFFF};
        load_settings(offs, ivals);
        queue_tick(1'b0);                               // off while off, count still moves
        queue_tick(1'b1);                               // on-time leaves the off value
        queue_tick(1'b1);                               // read of channel 0 still pending
        queue_response(2'd0, 1'b0, 32'h0, 1'b1);        // not done, stays pending
        queue_response(2'd0, 1'b1, 32'hFFFF_FFFF, 1'b1);// first read only stores
        queue_response(2'd0, 1'b1, 32'h0, 1'b1);        // nothing pending, ack only
        queue_response(2'd3, 1'b1, 32'h1234_0000, 1'b1);// channel never requested
        queue_tick(1'b1);
        queue_response(2'd0, 1'b1, 32'h0, 1'b1);        // changed and started
        queue_response(2'd1, 1'b1, 32'h1234_5678, 1'b1);
        queue_tick(1'b1);
        queue_response(2'd0, 1'b1, 32'h0, 1'b1);        // same value
        queue_tick(1'b1);
        queue_response(2'd0, 1'b1, 32'hA5A5_A5A5, 1'b0);// changed but event not started
        queue_tick(1'b1);
        queue_response(2'd0, 1'b1, 32'h5A5A_5A5A, 1'b1);
        queue_response(2'd2, 1'b1, 32'h8000_0001, 1'b1);
        queue_tick(1'b0);                               // ignition off clears all
        queue_response(2'd1, 1'b1, 32'h0BAD_F00D, 1'b1);// late response while off
        queue_tick(1'b0);
        queue_tick(1'b1);
        queue_response(2'd0, 1'b1, 32'hFFFF_FFFF, 1'b1);// first read after the clear
        queue_tick(1'b1);
        wait_drained();

        // random traffic under each idling mix
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            load_random_settings();
            send_idle_pct  = send_tab[p];
            recv_stall_pct = stall_tab[p];
            queue_traffic(20);
            if (p == 1)
            begin
                // sender sits out until every outstanding beat is back
                wait_drained();
            end
            queue_traffic(20);
            wait_drained();
        end

        // receiver holds off while the sender keeps pushing, so the input stalls
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_random_settings();
        hold_req++;
        queue_traffic(30);
        wait_drained();

        repeat (20) @(posedge clk);
        if (error_count == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("testbench: errors");
        $finish;
    end

endmodule
